[rtl/pkts_pkg.sv]
// Shared types, status codes and default sizes for the per-key task serializer.
// Used by every module of the block; depends on nothing.
package pkts_pkg;

    localparam int PKTS_KEY_ENTRIES = 16;
    localparam int PKTS_FIFO_DEPTH  = 8;
    localparam int PKTS_LOD_COUNT   = 8;

    localparam int LOD_W    = 3;
    localparam int POS_W    = 16;
    localparam int HANDLE_W = 16;
    localparam int KEY_W    = LOD_W + 3 * POS_W;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_UNKNOWN    = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_FIFO_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic hit;
        logic free_avail;
    } lookup_t;

    typedef struct packed {
        logic alloc;
        logic retire;
        logic push;
        logic pop;
    } tbl_cmd_t;

    // Folds a level index into the configured level count by repeated subtraction.
    function automatic logic [LOD_W-1:0] fold_lod(input logic [LOD_W-1:0] lod, input int n);
        logic [LOD_W-1:0] v;
        v = lod;
        for (int i = 0; i < (1 << LOD_W) - 1; i++)
        begin
            if (32'(v) >= n)
            begin
                v = v - LOD_W'(n);
            end
        end
        return v;
    endfunction

endpackage

[rtl/pkts_handle_ram.sv]
// Handle storage for all key FIFOs: one write and one registered read per cycle.
// Depends on pkts_pkg for the handle width.
module pkts_handle_ram
    import pkts_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic [HANDLE_W-1:0] wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output logic [HANDLE_W-1:0] rdata
);

    logic [HANDLE_W-1:0] mem [DEPTH];
    logic [HANDLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pkts_key_table.sv]
// Key table with parallel compare, lowest-free allocation and per-entry FIFO pointers.
// Depends on pkts_pkg for the key width and the lookup and command structs.
module pkts_key_table
    import pkts_pkg::*;
#(
    parameter int KEY_ENTRIES = PKTS_KEY_ENTRIES,
    parameter int FIFO_DEPTH  = PKTS_FIFO_DEPTH,
    parameter int EW          = $clog2(KEY_ENTRIES),
    parameter int HW          = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
    parameter int CW          = $clog2(FIFO_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [KEY_W-1:0] key,
    output lookup_t          lookup,
    output logic [EW-1:0]    hit_idx,
    output logic [HW-1:0]    hit_head,
    output logic [HW-1:0]    hit_tail,
    output logic [CW-1:0]    hit_count,
    input  tbl_cmd_t         cmd
);

    logic [KEY_ENTRIES-1:0] valid_reg;
    logic [KEY_W-1:0]       key_reg   [KEY_ENTRIES];
    logic [HW-1:0]          head_reg  [KEY_ENTRIES];
    logic [CW-1:0]          count_reg [KEY_ENTRIES];

    logic [KEY_ENTRIES-1:0] match;
    logic [EW-1:0]          free_idx;
    logic [CW:0]            tail_sum;
    logic [HW-1:0]          head_next;

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = KEY_ENTRIES - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == key);
            if (match[i])
            begin
                hit_idx = EW'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = EW'(i);
            end
        end
        lookup.hit        = |match;
        lookup.free_avail = ~&valid_reg;
    end

    assign hit_head  = head_reg[hit_idx];
    assign hit_count = count_reg[hit_idx];

    always_comb
    begin
        tail_sum = (CW+1)'(hit_head) + (CW+1)'(hit_count);
        if (tail_sum >= (CW+1)'(FIFO_DEPTH))
        begin
            tail_sum = tail_sum - (CW+1)'(FIFO_DEPTH);
        end
        hit_tail = HW'(tail_sum);
        if (hit_head == HW'(FIFO_DEPTH - 1))
        begin
            head_next = '0;
        end
        else
        begin
            head_next = hit_head + HW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < KEY_ENTRIES; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < KEY_ENTRIES; i++)
            begin
                if (cmd.alloc && free_idx == EW'(i))
                begin
                    valid_reg[i] <= 1'b1;
                    head_reg[i]  <= '0;
                    count_reg[i] <= '0;
                end
                else if (hit_idx == EW'(i))
                begin
                    if (cmd.retire)
                    begin
                        valid_reg[i] <= 1'b0;
                        head_reg[i]  <= '0;
                    end
                    else if (cmd.push)
                    begin
                        count_reg[i] <= hit_count + CW'(1);
                    end
                    else if (cmd.pop)
                    begin
                        head_reg[i]  <= head_next;
                        count_reg[i] <= hit_count - CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
        begin
            key_reg[free_idx] <= key;
        end
    end

endmodule

[rtl/per_key_task_serializer.sv]
// Top level of the per-key task serializer: input register, key table, handle memory
// and result register. Depends on pkts_pkg, pkts_key_table and pkts_handle_ram.
//
// The block takes one enqueue or dequeue item per cycle and returns exactly one result
// for each. An accepted item is held in an input register, where the key table compares
// its key against all entries. When the item advances, the entry is updated and the
// result is loaded into the output register together with the registered read of the
// handle memory, so a result passes the input register and then the output register.
// The whole lookup and update are done while the item is in the input register, so a
// new item can be accepted in every cycle while the receiver takes results. A result
// that waits in the output register holds the input register and so stalls the input.
// The key table starts empty right after reset; no clearing pass is needed.
module per_key_task_serializer
    import pkts_pkg::*;
#(
    parameter int KEY_ENTRIES = PKTS_KEY_ENTRIES,
    parameter int FIFO_DEPTH  = PKTS_FIFO_DEPTH,
    parameter int LOD_COUNT   = PKTS_LOD_COUNT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       mode,
    input  logic [LOD_W-1:0]           lod,
    input  logic signed [POS_W-1:0]    pos_x,
    input  logic signed [POS_W-1:0]    pos_y,
    input  logic signed [POS_W-1:0]    pos_z,
    input  logic [HANDLE_W-1:0]        task_handle,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic                       deferred,
    output logic                       next_valid,
    output logic [HANDLE_W-1:0]        next_handle
);

    localparam int EW     = $clog2(KEY_ENTRIES);
    localparam int HW     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW     = $clog2(FIFO_DEPTH + 1);
    localparam int MDEPTH = KEY_ENTRIES * FIFO_DEPTH;
    localparam int AW     = $clog2(MDEPTH);

    logic                    s1_valid_reg;
    logic                    s1_mode_reg;
    logic [LOD_W-1:0]        s1_lod_reg;
    logic [POS_W-1:0]        s1_x_reg;
    logic [POS_W-1:0]        s1_y_reg;
    logic [POS_W-1:0]        s1_z_reg;
    logic [HANDLE_W-1:0]     s1_handle_reg;

    logic                    out_valid_reg;
    status_t                 status_reg;
    status_t                 status_next;
    logic                    deferred_reg;
    logic                    deferred_next;
    logic                    next_valid_reg;
    logic                    next_valid_next;

    logic                    adv;
    logic [KEY_W-1:0]        key;
    lookup_t                 lookup;
    tbl_cmd_t                cmd;
    logic [EW-1:0]           hit_idx;
    logic [HW-1:0]           hit_head;
    logic [HW-1:0]           hit_tail;
    logic [CW-1:0]           hit_count;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           raddr;
    logic [HANDLE_W-1:0]     ram_rdata;

    assign adv      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv;
    assign key      = {fold_lod(s1_lod_reg, LOD_COUNT), s1_x_reg, s1_y_reg, s1_z_reg};

    pkts_key_table #(
        .KEY_ENTRIES (KEY_ENTRIES),
        .FIFO_DEPTH  (FIFO_DEPTH),
        .EW          (EW),
        .HW          (HW),
        .CW          (CW)
    ) u_key_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key),
        .lookup    (lookup),
        .hit_idx   (hit_idx),
        .hit_head  (hit_head),
        .hit_tail  (hit_tail),
        .hit_count (hit_count),
        .cmd       (cmd)
    );

    always_comb
    begin
        cmd             = '0;
        status_next     = ST_OK;
        deferred_next   = 1'b0;
        next_valid_next = 1'b0;
        if (s1_mode_reg == MODE_ENQ)
        begin
            if (lookup.hit)
            begin
                if (hit_count == CW'(FIFO_DEPTH))
                begin
                    status_next = ST_FIFO_FULL;
                end
                else
                begin
                    cmd.push      = 1'b1;
                    deferred_next = 1'b1;
                end
            end
            else if (lookup.free_avail)
            begin
                cmd.alloc = 1'b1;
            end
            else
            begin
                status_next = ST_TABLE_FULL;
            end
        end
        else
        begin
            if (!lookup.hit)
            begin
                status_next = ST_UNKNOWN;
            end
            else if (hit_count == '0)
            begin
                cmd.retire = 1'b1;
            end
            else
            begin
                cmd.pop         = 1'b1;
                next_valid_next = 1'b1;
            end
        end
        if (!adv)
        begin
            cmd = '0;
        end
    end

    assign waddr = AW'(hit_idx) * AW'(FIFO_DEPTH) + AW'(hit_tail);
    assign raddr = AW'(hit_idx) * AW'(FIFO_DEPTH) + AW'(hit_head);

    pkts_handle_ram #(
        .DEPTH (MDEPTH),
        .AW    (AW)
    ) u_handle_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (waddr),
        .wdata (s1_handle_reg),
        .re    (cmd.pop),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_mode_reg   <= mode;
            s1_lod_reg    <= lod;
            s1_x_reg      <= pos_x;
            s1_y_reg      <= pos_y;
            s1_z_reg      <= pos_z;
            s1_handle_reg <= task_handle;
        end
        if (adv)
        begin
            status_reg     <= status_next;
            deferred_reg   <= deferred_next;
            next_valid_reg <= next_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign deferred    = deferred_reg;
    assign next_valid  = next_valid_reg;
    assign next_handle = next_valid_reg ? ram_rdata : '0;

`ifndef SYNTHESIS
    a_pop_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && next_valid |-> status == ST_OK && !deferred)
        else $error("returned handle with error status or deferred flag");

    a_defer_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && deferred |-> status == ST_OK && !next_valid)
        else $error("deferred enqueue with error status or handle");

    a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled while output is free");

    a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_valid |=> out_valid)
        else $error("captured item did not reach the result register");
`endif

endmodule
